/* hw/rtl/mlfw_pkg.sv */
package mlfw_pkg;

    localparam int PROC_W = 4;
    localparam int MASK_W = 16;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;
    localparam int LOCK_W = 3;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] SLOTS_PER_LOCK = 5'd16;

    localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SIGNAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_CONT    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BLOCKED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERROR   = 2'd2;

    typedef struct packed {
        logic              held;
        logic [PROC_W-1:0] owner;
        logic [SLOT_W-1:0] head;
        logic [CNT_W-1:0]  count;
        logic [MASK_W-1:0] wmask;
    } lock_entry_t;

endpackage

/* hw/rtl/mlfw_lock_table.sv */
module mlfw_lock_table
    import mlfw_pkg::*;
#(
    parameter int NUM_LOCKS = 4,
    parameter int AW        = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output lock_entry_t   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  lock_entry_t   wr_data
);

    lock_entry_t mem [NUM_LOCKS];
    lock_entry_t rd_word_reg;
    logic [NUM_LOCKS-1:0] valid_reg;
    logic rd_valid_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

/* hw/rtl/mlfw_wait_ram.sv */
module mlfw_wait_ram
    import mlfw_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [PROC_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [PROC_W-1:0] wr_data
);

    logic [PROC_W-1:0] mem [DEPTH];
    logic [PROC_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/mutex_lock_with_fifo_waiters.sv */
// an accepted input beat passes through ST_ENT and ST_EXEC; its result beat is registered
// on m_tdata; ST_EXEC holds while an earlier result is stalled; only ST_IDLE takes new items
// the lock entry read and the dependent wait queue read are synchronous memory reads
// the output register lets the next item enter while a result waits
// reset: asynchronous active low; all locks free, queues empty, masks clear
module mutex_lock_with_fifo_waiters
    import mlfw_pkg::*;
#(
    parameter int NUM_LOCKS = 4,
    parameter int MAX_PROCS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,   // cmd
    input  logic [7:0] s_tdata,   // lock_index, proc_id
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // status, wake_valid, wake_id
);

    localparam int LK_AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int WQ_AW = LK_AW + SLOT_W;
    localparam logic [LOCK_W:0] LOCK_LIM = (LOCK_W + 1)'(NUM_LOCKS);
    localparam logic [PROC_W:0] PROC_LIM = (PROC_W + 1)'(MAX_PROCS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ENT  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [LOCK_W-1:0] lk_reg;
    logic [PROC_W-1:0] pid_reg;
    logic [MASK_W-1:0] blocked_reg, blocked_next;
    logic [MASK_W-1:0] finished_reg, finished_next;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;

    logic s_fire, exec_fire;
    lock_entry_t ent, ent_next;
    logic tbl_we;
    logic [PROC_W-1:0] wq_q;
    logic wq_we;
    logic [SLOT_W-1:0] wq_slot;
    logic [WQ_AW-1:0] wq_waddr;
    logic [MASK_W-1:0] pbit, nbit;
    logic own;
    logic [STAT_W-1:0] status;
    logic wv;
    logic [PROC_W-1:0] wid;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    mlfw_lock_table #(
        .NUM_LOCKS (NUM_LOCKS),
        .AW        (LK_AW)
    ) u_tbl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_fire),
        .rd_addr (s_tdata[LK_AW-1:0]),
        .rd_data (ent),
        .wr_en   (tbl_we && exec_fire),
        .wr_addr (lk_reg[LK_AW-1:0]),
        .wr_data (ent_next)
    );

    mlfw_wait_ram #(
        .DEPTH (NUM_LOCKS * (1 << SLOT_W)),
        .AW    (WQ_AW)
    ) u_wq (
        .clk     (clk),
        .rd_en   (state_reg == ST_ENT),
        .rd_addr ({lk_reg[LK_AW-1:0], ent.head}),
        .rd_data (wq_q),
        .wr_en   (wq_we && exec_fire),
        .wr_addr (wq_waddr),
        .wr_data (pid_reg)
    );

    assign pbit     = MASK_W'(1) << pid_reg;
    assign nbit     = MASK_W'(1) << wq_q;
    assign own      = ent.held && (ent.owner == pid_reg);
    assign wq_slot  = ent.head + ent.count[SLOT_W-1:0];
    assign wq_waddr = {lk_reg[LK_AW-1:0], wq_slot};

    always_comb
    begin
        status        = STAT_CONT;
        wv            = 1'b0;
        wid           = '0;
        ent_next      = ent;
        tbl_we        = 1'b0;
        wq_we         = 1'b0;
        blocked_next  = blocked_reg;
        finished_next = finished_reg;
        if ({1'b0, pid_reg} >= PROC_LIM)
        begin
            status = STAT_ERROR;
        end
        else
        begin
            case (cmd_reg)
                CMD_FINISH:
                begin
                    finished_next = finished_reg | pbit;
                end
                CMD_WAIT:
                begin
                    if ({1'b0, lk_reg} >= LOCK_LIM)
                    begin
                        status = STAT_ERROR;
                    end
                    else if (own)
                    begin
                        status = STAT_CONT;
                    end
                    else if (!ent.held)
                    begin
                        ent_next.held  = 1'b1;
                        ent_next.owner = pid_reg;
                        tbl_we         = 1'b1;
                    end
                    else
                    begin
                        blocked_next = blocked_reg | pbit;
                        if (((ent.wmask & pbit) == '0) && (ent.count < SLOTS_PER_LOCK))
                        begin
                            wq_we          = 1'b1;
                            ent_next.count = ent.count + CNT_W'(1);
                            ent_next.wmask = ent.wmask | pbit;
                            tbl_we         = 1'b1;
                        end
                        status = STAT_BLOCKED;
                    end
                end
                CMD_SIGNAL:
                begin
                    if ({1'b0, lk_reg} >= LOCK_LIM)
                    begin
                        status = STAT_ERROR;
                    end
                    else if (own)
                    begin
                        tbl_we = 1'b1;
                        if (ent.count == '0)
                        begin
                            ent_next.held  = 1'b0;
                            ent_next.owner = '0;
                        end
                        else
                        begin
                            ent_next.head  = ent.head + SLOT_W'(1);
                            ent_next.count = ent.count - CNT_W'(1);
                            ent_next.wmask = ent.wmask & ~nbit;
                            blocked_next   = blocked_reg & ~nbit;
                            // a finished waiter is dropped and the signaller keeps the lock
                            if ((finished_reg & nbit) == '0)
                            begin
                                ent_next.owner = wq_q;
                                wv             = 1'b1;
                                wid            = wq_q;
                            end
                        end
                    end
                end
                default:
                begin
                    status = STAT_ERROR;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_ENT;
                end
            end
            ST_ENT:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            blocked_reg   <= '0;
            finished_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                blocked_reg   <= blocked_next;
                finished_reg  <= finished_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg <= s_tuser;
            lk_reg  <= s_tdata[2:0];
            pid_reg <= s_tdata[6:3];
        end
        if (exec_fire)
        begin
            out_data_reg <= {1'b0, wid, wv, status};
        end
    end

endmodule

/* hw/rtl/mlfw_checker.sv */
module mlfw_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while first in flight");

    // a wake only comes with a continue status
    a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0)
        else $error("wake reported with non-continue status");

    // no wake means zero wake id and no unused status code
    a_no_wake_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[6:3] == 4'd0 && m_tdata[1:0] != 2'd3)
        else $error("bad result beat contents");

endmodule

bind mutex_lock_with_fifo_waiters mlfw_checker u_mlfw_checker (.*);

/* tb/mutex_lock_with_fifo_waiters_tb.sv */
module mutex_lock_with_fifo_waiters_tb
    import mlfw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_LOCKS = 4;
    localparam int N_PROCS = 16;
    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              wake;
        logic [PROC_W-1:0] wake_id;
    } lock_reply_t;

    class mutex_bank_model;
        logic              held [N_LOCKS];
        logic [PROC_W-1:0] owner [N_LOCKS];
        logic [PROC_W-1:0] fifo [N_LOCKS][16];
        logic [SLOT_W-1:0] head [N_LOCKS];
        logic [CNT_W-1:0]  count [N_LOCKS];
        logic [MASK_W-1:0] waiting [N_LOCKS];
        logic [MASK_W-1:0] blocked;
        logic [MASK_W-1:0] finished;
        lock_reply_t       replies_due [$];
        int                mismatches;

        function void clear();
            for (int i = 0; i < N_LOCKS; i++)
            begin
                held[i] = 1'b0;
                owner[i] = '0;
                head[i] = '0;
                count[i] = '0;
                waiting[i] = '0;
            end
            blocked = '0;
            finished = '0;
            mismatches = 0;
            replies_due.delete();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [LOCK_W-1:0] lk,
                                   logic [PROC_W-1:0] pid);
            lock_reply_t       r;
            logic [MASK_W-1:0] pbit;
            logic [MASK_W-1:0] nbit;
            logic [PROC_W-1:0] nxt;
            logic [SLOT_W-1:0] slot;
            int                li;
            r = '0;
            r.status = STAT_CONT;
            pbit = 16'b1 << pid;
            li = int'(lk);
            if (cmd == CMD_BAD || int'(pid) >= N_PROCS)
            begin
                r.status = STAT_ERROR;
            end
            else if (cmd == CMD_FINISH)
            begin
                finished = finished | pbit;
            end
            else if (li >= N_LOCKS)
            begin
                r.status = STAT_ERROR;
            end
            else if (cmd == CMD_WAIT)
            begin
                if (held[li] && owner[li] == pid)
                begin
                    r.status = STAT_CONT;
                end
                else if (!held[li])
                begin
                    held[li] = 1'b1;
                    owner[li] = pid;
                end
                else
                begin
                    blocked = blocked | pbit;
                    if ((waiting[li] & pbit) == '0 && count[li] < SLOTS_PER_LOCK)
                    begin
                        slot = head[li] + count[li][SLOT_W-1:0];
                        fifo[li][slot] = pid;
                        count[li] = count[li] + 1'b1;
                        waiting[li] = waiting[li] | pbit;
                    end
                    r.status = STAT_BLOCKED;
                end
            end
            else if (held[li] && owner[li] == pid)
            begin
                if (count[li] == '0)
                begin
                    held[li] = 1'b0;
                    owner[li] = '0;
                end
                else
                begin
                    nxt = fifo[li][head[li]];
                    nbit = 16'b1 << nxt;
                    head[li] = head[li] + 1'b1;
                    count[li] = count[li] - 1'b1;
                    waiting[li] = waiting[li] & ~nbit;
                    blocked = blocked & ~nbit;
                    if ((finished & nbit) == '0)
                    begin
                        owner[li] = nxt;
                        held[li] = 1'b1;
                        r.wake = 1'b1;
                        r.wake_id = nxt;
                    end
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [7:0] beat);
            lock_reply_t want;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", beat);
                return;
            end
            want = replies_due.pop_front();
            if (beat[1:0] !== want.status || beat[2] !== want.wake
                || beat[6:3] !== want.wake_id)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d wake %0d/%0d wake_id %0d/%0d (exp/act)",
                             want.status, beat[1:0], want.wake, beat[2],
                             want.wake_id, beat[6:3]);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [1:0] s_tuser = '0;
    logic [7:0] s_tdata = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    mutex_bank_model sb;
    int  tx_gap_pct = 20;
    int  rx_stall_pct = 10;
    bit  rx_hold_req = 1'b0;

    mutex_lock_with_fifo_waiters #(
        .NUM_LOCKS(N_LOCKS),
        .MAX_PROCS(N_PROCS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid === 1'b1 && m_tready)
                sb.check_reply(m_tdata);
            if (s_tvalid && s_tready === 1'b1)
                sb.note_request(s_tuser, s_tdata[2:0], s_tdata[6:3]);
        end
    end

    // result side: random stalls, plus one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (120) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [LOCK_W-1:0] lk,
                                input logic [PROC_W-1:0] pid);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, pid, lk};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        if ($urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic wait_all_replies();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        logic [CMD_W-1:0]  cmd;
        logic [LOCK_W-1:0] lk;
        logic [PROC_W-1:0] pid;
        int                r;
        r = $urandom_range(0, 299);
        lk = LOCK_W'($urandom_range(0, N_LOCKS - 1));
        pid = PROC_W'($urandom_range(0, N_PROCS - 1));
        if (r < 6)
        begin
            cmd = CMD_BAD;
            lk = LOCK_W'($urandom_range(0, 7));
        end
        else if (r < 12)
        begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_WAIT : CMD_SIGNAL;
            lk = LOCK_W'($urandom_range(N_LOCKS, 7));
        end
        else if (r < 14)
        begin
            cmd = CMD_FINISH;
            lk = LOCK_W'($urandom_range(0, 7));
        end
        else if (r < 150)
        begin
            cmd = CMD_WAIT;
        end
        else
        begin
            cmd = CMD_SIGNAL;
            if (sb.held[lk] && $urandom_range(0, 99) < 75)
                pid = sb.owner[lk];
        end
        send_request(cmd, lk, pid);
    endtask

    initial
    begin
        #20_000_000;
        $display("[mutex_lock_with_fifo_waiters] ERROR");
        $finish;
    end

    initial
    begin
        sb = new;
        sb.clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_BAD, 3'd7, 4'd15);
        send_request(CMD_FINISH, 3'd5, 4'd9);
        send_request(CMD_WAIT, 3'd4, 4'd1);
        send_request(CMD_SIGNAL, 3'd7, 4'd1);
        send_request(CMD_SIGNAL, 3'd0, 4'd0);
        send_request(CMD_WAIT, 3'd0, 4'd0);
        send_request(CMD_WAIT, 3'd0, 4'd0);
        send_request(CMD_WAIT, 3'd0, 4'd15);
        send_request(CMD_WAIT, 3'd0, 4'd15);
        send_request(CMD_WAIT, 3'd0, 4'd9);
        send_request(CMD_WAIT, 3'd0, 4'd5);
        send_request(CMD_SIGNAL, 3'd0, 4'd5);
        send_request(CMD_SIGNAL, 3'd0, 4'd0);
        send_request(CMD_SIGNAL, 3'd0, 4'd15);
        send_request(CMD_SIGNAL, 3'd0, 4'd15);
        send_request(CMD_SIGNAL, 3'd0, 4'd5);
        send_request(CMD_WAIT, 3'd3, 4'd10);
        send_request(CMD_WAIT, 3'd3, 4'd6);
        send_request(CMD_SIGNAL, 3'd3, 4'd10);
        send_request(CMD_SIGNAL, 3'd3, 4'd6);
        send_request(CMD_BAD, 3'd0, 4'd0);
        wait_all_replies();

        for (int n = 0; n < 1330; n++)
        begin
            if (n == 300)
            begin
                // hold the result side while beats keep coming
                tx_gap_pct = 0;
                rx_hold_req = 1'b1;
            end
            if (n == 360)
                tx_gap_pct = 20;
            if (n == 650)
                wait_all_replies();
            if (n == 800)
            begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end
            if (n == 900)
            begin
                tx_gap_pct = 30;
                rx_stall_pct = 20;
            end
            if (n == 1030)
            begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end
            send_random_request();
        end

        wait_all_replies();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.replies_due.size() == 0)
            $display("[mutex_lock_with_fifo_waiters] OK");
        else
            $display("[mutex_lock_with_fifo_waiters] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/mlfw_pkg.sv
hw/rtl/mlfw_lock_table.sv
hw/rtl/mlfw_wait_ram.sv
hw/rtl/mutex_lock_with_fifo_waiters.sv
hw/rtl/mlfw_checker.sv
tb/mutex_lock_with_fifo_waiters_tb.sv
